@@ design/ffa_pkg.sv @@
// Shared constants, types and codes for the first-fit block allocator.
package ffa_pkg;

	localparam int NUM_BLOCKS = 256;
	localparam int IDX_W      = 8;
	localparam int LEN_W      = 9;

	localparam logic       CMD_ALLOC  = 1'b0;
	localparam logic       CMD_FREE   = 1'b1;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADPTR  = 2'd2;

	typedef struct packed {
		logic             used;
		logic [LEN_W-1:0] len;
	} cell_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_FREE
	} state_t;

endpackage

@@ design/ffa_cell.sv @@
// One block cell of the rotating map: used bit and run length.
module ffa_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  ffa_pkg::cell_t din,
	output ffa_pkg::cell_t dout
);

	ffa_pkg::cell_t cell_q;

	// advance the ring by one cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (shift) begin
			cell_q <= din;
		end
	end

	assign dout = cell_q;

endmodule

@@ design/first_fit_block_allocator_core.sv @@
// First-fit block allocator top level: ring of block cells and its sequencer.
//
// Usage: drive command, size_bytes and free_offset and raise start while busy
// is low; the request is taken at that edge. Exactly one result follows:
// done is high for one cycle with result_offset and status valid.
// The block map lives in a ring of 256 cells that, while busy is high, rotates
// one cell per cycle past a head cell that the sequencer reads and rewrites.
// Passes: an allocate scans one rotation for the first free run; done rises at
// the end of that scan when no run fits, and after a second rotation that marks
// the run when one is found. A free takes one rotation, then done rises.
// Requests that are rejected at once (too large, misaligned free offset) raise
// done in the cycle right after they are taken.
// Throughput: one request at a time; the next may be taken in the cycle done
// is high.
// Reset: all blocks free and no allocation recorded; takes effect at once.
// The receiver cannot stall: done is a single-cycle strobe.
module first_fit_block_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [10:0] size_bytes,
	input  logic [9:0]  free_offset,
	output logic        done,
	output logic [9:0]  result_offset,
	output logic [1:0]  status
);

	localparam int NB = ffa_pkg::NUM_BLOCKS;

	ffa_pkg::cell_t  ring_out [NB];
	ffa_pkg::cell_t  head_new;
	ffa_pkg::cell_t  head;
	ffa_pkg::state_t state_q, state_d;

	logic [ffa_pkg::IDX_W-1:0] idx_q;
	logic [ffa_pkg::IDX_W-1:0] start_q;
	logic [ffa_pkg::LEN_W-1:0] need_q;
	logic [ffa_pkg::LEN_W-1:0] runlen_q;
	logic [ffa_pkg::LEN_W-1:0] cnt_q;
	logic                      found_q;
	logic                      hit_q;
	logic                      done_q;
	logic [9:0]                offset_q;
	logic [1:0]                status_q;
	logic                      shift;
	logic                      accept;
	logic [9:0]                need_raw;
	logic                      at_start;
	logic                      last;
	logic                      found_now;
	logic                      hit_now;

	assign head     = ring_out[0];
	assign shift    = (state_q != ffa_pkg::S_IDLE);
	assign accept   = start && !busy;
	assign need_raw = {1'b0, size_bytes[10:2]} + {9'd0, |size_bytes[1:0]};
	assign at_start = (idx_q == start_q);
	assign last     = (idx_q == ffa_pkg::IDX_W'(NB - 1));
	assign found_now = found_q || (!head.used && ((runlen_q + 1'b1) == need_q));
	assign hit_now  = hit_q || (at_start && (head.len != '0));

	// ring of cells, head cell rewritten on its way to the tail
	for (genvar i = 0; i < NB; i++) begin : g_cell
		if (i == NB - 1) begin : g_tail
			ffa_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
				.din(head_new), .dout(ring_out[i]));
		end else begin : g_body
			ffa_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
				.din(ring_out[i+1]), .dout(ring_out[i]));
		end
	end

	// rewrite head cell during mark and free passes
	always_comb begin
		head_new = head;
		case (state_q)
			ffa_pkg::S_MARK: begin
				if (at_start) begin
					head_new.used = 1'b1;
					head_new.len  = need_q;
				end else if (cnt_q != '0) begin
					head_new.used = 1'b1;
				end
			end
			ffa_pkg::S_FREE: begin
				if (at_start && head.len != '0) begin
					head_new.used = 1'b0;
					head_new.len  = '0;
				end else if (!at_start && cnt_q != '0) begin
					head_new.used = 1'b0;
				end
			end
			default: head_new = head;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffa_pkg::S_IDLE: begin
				if (accept) begin
					if (command == ffa_pkg::CMD_ALLOC) begin
						if (need_raw <= 10'(NB)) state_d = ffa_pkg::S_SCAN;
					end else if (free_offset[1:0] == 2'b00) begin
						state_d = ffa_pkg::S_FREE;
					end
				end
			end
			ffa_pkg::S_SCAN: if (last) state_d = found_now ? ffa_pkg::S_MARK : ffa_pkg::S_IDLE;
			ffa_pkg::S_MARK: if (last) state_d = ffa_pkg::S_IDLE;
			ffa_pkg::S_FREE: if (last) state_d = ffa_pkg::S_IDLE;
			default:         state_d = ffa_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			start_q  <= '0;
			need_q   <= '0;
			runlen_q <= '0;
			cnt_q    <= '0;
			found_q  <= 1'b0;
			hit_q    <= 1'b0;
			done_q   <= 1'b0;
			offset_q <= '0;
			status_q <= ffa_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			if (shift) idx_q <= idx_q + 1'b1;
			case (state_q)
				ffa_pkg::S_IDLE: begin
					idx_q    <= '0;
					runlen_q <= '0;
					cnt_q    <= '0;
					found_q  <= 1'b0;
					hit_q    <= 1'b0;
					if (accept) begin
						need_q  <= (need_raw == '0) ? ffa_pkg::LEN_W'(1) : need_raw[8:0];
						start_q <= free_offset[9:2];
						if (command == ffa_pkg::CMD_ALLOC && need_raw > 10'(NB)) begin
							done_q   <= 1'b1;
							offset_q <= '0;
							status_q <= ffa_pkg::ST_NOSPACE;
						end else if (command == ffa_pkg::CMD_FREE &&
							free_offset[1:0] != 2'b00) begin
							done_q   <= 1'b1;
							offset_q <= '0;
							status_q <= ffa_pkg::ST_BADPTR;
						end
					end
				end
				ffa_pkg::S_SCAN: begin
					if (!found_q) begin
						if (head.used) begin
							runlen_q <= '0;
						end else begin
							if (runlen_q == '0) start_q <= idx_q;
							runlen_q <= runlen_q + 1'b1;
							if ((runlen_q + 1'b1) == need_q) found_q <= 1'b1;
						end
					end
					if (last && !found_now) begin
						done_q   <= 1'b1;
						offset_q <= '0;
						status_q <= ffa_pkg::ST_NOSPACE;
					end
				end
				ffa_pkg::S_MARK: begin
					if (at_start) cnt_q <= need_q - 1'b1;
					else if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
					if (last) begin
						done_q   <= 1'b1;
						offset_q <= {start_q, 2'b00};
						status_q <= ffa_pkg::ST_OK;
					end
				end
				ffa_pkg::S_FREE: begin
					if (at_start && head.len != '0) begin
						hit_q <= 1'b1;
						cnt_q <= head.len - 1'b1;
					end else if (!at_start && cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end
					if (last) begin
						done_q   <= 1'b1;
						offset_q <= '0;
						status_q <= hit_now ? ffa_pkg::ST_OK : ffa_pkg::ST_BADPTR;
					end
				end
				default: ;
			endcase
		end
	end

	assign busy          = (state_q != ffa_pkg::S_IDLE);
	assign done          = done_q;
	assign result_offset = offset_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while a pass runs");
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result_offset[1:0] == 2'b00) else $error("misaligned offset");
	a_mark_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffa_pkg::S_MARK |-> found_q) else $error("mark without a run");
`endif

endmodule
